/* hdl/xtea_block_cipher_unit_defines.svh */
// ----------------------------------------------------------------------------
// XTEA block cipher unit - assertion macros
// Shared concurrent assertion forms used by the cipher unit.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define XTEA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define XTEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/xtea_pkg.sv */
// ----------------------------------------------------------------------------
// XTEA package
// Payload types, key storage type, register indexes and cipher constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xtea_pkg;

    // Cipher constants
    localparam logic [31:0] XTEA_DELTA     = 32'h9E37_79B9;
    localparam int          XTEA_KEY_SHIFT = 11;

    // Operation codes carried in the op field
    localparam logic        OP_ENCRYPT     = 1'b0;
    localparam logic        OP_DECRYPT     = 1'b1;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 3;
    localparam logic [2:0]  REG_KEY_WORD_0 = 3'd0;
    localparam logic [2:0]  REG_KEY_WORD_1 = 3'd1;
    localparam logic [2:0]  REG_KEY_WORD_2 = 3'd2;
    localparam logic [2:0]  REG_KEY_WORD_3 = 3'd3;
    localparam logic [2:0]  REG_ROUND_CNT  = 3'd4;

    localparam int          ROUND_CNT_W    = 6;
    localparam logic [5:0]  ROUND_CNT_RST  = 6'd32;

    // Input item
    typedef struct packed {
        logic        op;
        logic [31:0] block_left;
        logic [31:0] block_right;
    } xtea_item_t;

    // Result item
    typedef struct packed {
        logic [31:0] result_left;
        logic [31:0] result_right;
    } xtea_result_t;

    // Working words that travel down the cell chain
    typedef struct packed {
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
    } xtea_lane_t;

    // 128-bit key as four words
    typedef logic [3:0][31:0] xtea_key_t;

endpackage

/* hdl/xtea_cell.sv */
// ----------------------------------------------------------------------------
// XTEA cell
// One Feistel half-round. Even cells update one half and step the running
// sum, odd cells update the other half. Cells past the cycle count pass data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea_cell
    import xtea_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int CNT_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  xtea_key_t        key,
    input  logic             valid_in,
    input  logic [CNT_W-1:0] n_in,
    input  xtea_lane_t       lane_in,
    output logic             valid_out,
    output logic [CNT_W-1:0] n_out,
    output xtea_lane_t       lane_out
);

    localparam int   CYCLE    = STAGE / 2;
    localparam logic HALF_BIT = 1'(STAGE % 2);

    logic             valid_reg;
    logic [CNT_W-1:0] n_reg;
    xtea_lane_t       lane_reg;
    xtea_lane_t       lane_next;

    logic        active;
    logic        upd_a;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] mix_val;
    logic [1:0]  key_sel;
    logic [31:0] round_f;
    logic [31:0] dst_new;

    // Half-round datapath
    always_comb
    begin
        active  = (n_in > CNT_W'(CYCLE));
        // encrypt even half and decrypt odd half update the left word
        upd_a   = (lane_in.op == HALF_BIT);
        src     = upd_a ? lane_in.b : lane_in.a;
        dst     = upd_a ? lane_in.a : lane_in.b;
        mix_val = ((src << 4) ^ (src >> 5)) + src;
        key_sel = upd_a ? lane_in.sum[1:0]
                        : lane_in.sum[XTEA_KEY_SHIFT+1:XTEA_KEY_SHIFT];
        round_f = mix_val ^ (lane_in.sum + key[key_sel]);
        dst_new = lane_in.op ? (dst - round_f) : (dst + round_f);

        lane_next = lane_in;
        if (active)
        begin
            if (upd_a)
            begin
                lane_next.a = dst_new;
            end
            else
            begin
                lane_next.b = dst_new;
            end
            // running sum steps between the two halves of a cycle
            if (HALF_BIT == 1'b0)
            begin
                lane_next.sum = lane_in.op ? (lane_in.sum - XTEA_DELTA)
                                           : (lane_in.sum + XTEA_DELTA);
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        n_reg    <= n_in;
        lane_reg <= lane_next;
    end

    assign valid_out = valid_reg;
    assign n_out     = n_reg;
    assign lane_out  = lane_reg;

endmodule

/* hdl/xtea_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// XTEA block cipher unit
// 64-bit block XTEA encrypt/decrypt with a fully unrolled half-round chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; the transfer happens at a clock edge
//   with start high and busy low. busy stays low, so a block can be given
//   every cycle. item.op selects encrypt (0) or decrypt (1).
//   Output: done is high for one cycle with the processed block on result;
//   that cycle's closing edge is the transfer. There is no backpressure.
//   Path: from the input transfer through the input register, then one cell
//   per Feistel half-round, to done. Throughput is one block per cycle.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data. Indexes 0..3 are
//   the key words, 4 the cycle count (saturates at MAX_ROUNDS, 0 passes the
//   block through); other indexes are dropped. Write only while idle.
//   Reset: clears all valid bits, keys to 0 and cycle count to 32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xtea_block_cipher_unit_defines.svh"

module xtea_block_cipher_unit
    import xtea_pkg::*;
#(
    parameter int MAX_ROUNDS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  xtea_item_t           item,
    output logic                 done,
    output xtea_result_t         result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int NCELL   = 2 * MAX_ROUNDS;
    localparam int CNT_W   = $clog2(MAX_ROUNDS + 1);
    localparam int LATENCY = NCELL + 1;

    // Configuration registers
    xtea_key_t              key_reg;
    logic [ROUND_CNT_W-1:0] rounds_reg;

    // Chain taps: index 0 is the input register, index k the output of cell k-1
    logic                   stage_valid [0:NCELL];
    logic [CNT_W-1:0]       stage_n     [0:NCELL];
    xtea_lane_t             stage_lane  [0:NCELL];

    logic                   in_valid_reg;
    logic [CNT_W-1:0]       in_n_reg;
    xtea_lane_t             in_lane_reg;
    xtea_lane_t             in_lane_next;
    logic [CNT_W-1:0]       n_sat;
    logic                   accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= ROUND_CNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_WORD_0: key_reg[0] <= cfg_data;
                REG_KEY_WORD_1: key_reg[1] <= cfg_data;
                REG_KEY_WORD_2: key_reg[2] <= cfg_data;
                REG_KEY_WORD_3: key_reg[3] <= cfg_data;
                REG_ROUND_CNT:  rounds_reg <= cfg_data[ROUND_CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Saturated cycle count and initial sum
    always_comb
    begin
        n_sat = (int'(rounds_reg) > MAX_ROUNDS) ? CNT_W'(MAX_ROUNDS)
                                                : CNT_W'(rounds_reg);
        in_lane_next.op  = item.op;
        in_lane_next.a   = item.block_left;
        in_lane_next.b   = item.block_right;
        in_lane_next.sum = item.op ? 32'(XTEA_DELTA * 32'(n_sat)) : 32'd0;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        in_n_reg    <= n_sat;
        in_lane_reg <= in_lane_next;
    end

    assign stage_valid[0] = in_valid_reg;
    assign stage_n[0]     = in_n_reg;
    assign stage_lane[0]  = in_lane_reg;

    // Half-round cell chain
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        xtea_cell #(
            .STAGE (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .valid_in  (stage_valid[k]),
            .n_in      (stage_n[k]),
            .lane_in   (stage_lane[k]),
            .valid_out (stage_valid[k+1]),
            .n_out     (stage_n[k+1]),
            .lane_out  (stage_lane[k+1])
        );
    end

    // Result strobe and payload
    assign done                = stage_valid[NCELL];
    assign result.result_left  = stage_lane[NCELL].a;
    assign result.result_right = stage_lane[NCELL].b;

    // Assertions
    `XTEA_ASSERT_IMPLY(a_done_follows_accept, clk, rst_n,
        done, $past(accept, LATENCY), "done without a matching input transfer")
    `XTEA_ASSERT_IMPLY(a_zero_rounds_pass, clk, rst_n,
        done && $past(accept && (rounds_reg == '0), LATENCY),
        (result.result_left == $past(item.block_left, LATENCY)) &&
        (result.result_right == $past(item.block_right, LATENCY)),
        "zero cycle count did not pass the block through")
    `XTEA_ASSERT_NEXT(a_chain_entry, clk, rst_n,
        accept, in_valid_reg && (in_n_reg <= CNT_W'(MAX_ROUNDS)),
        "input transfer not captured or cycle count not saturated")

endmodule
